// ===== rtl/glzw_pkg.sv =====
// ----------------------------------------------------------------------------
// glzw_pkg
// Shared types and constants of the GIF LZW encoder.
// ----------------------------------------------------------------------------
package glzw_pkg;

	localparam int TABLE_ENTRIES  = 4096;
	localparam int CODE_W         = 12;
	localparam int MAX_CODE_W     = 12;
	localparam int HASH_SLOTS_DEF = 1024;

	localparam logic [3:0]  COLOR_BITS_RESET = 4'd8;
	localparam logic [12:0] EMPTY_CODE       = 13'h1FFF;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_PIXEL = 2'd1,
		CMD_END   = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [CODE_W-1:0] prefix;
		logic [7:0]        suffix;
		logic [CODE_W-1:0] chain;
	} entry_t;

	typedef struct packed {
		logic              re;
		logic [CODE_W-1:0] raddr;
		logic              we;
		logic [CODE_W-1:0] waddr;
		entry_t            wdata;
	} ent_req_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_ROOT,
		ST_HEAD,
		ST_ENT,
		ST_PUT,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

	typedef enum logic [2:0] {
		RET_CLR,
		RET_ADD,
		RET_FULL,
		RET_END1,
		RET_END2
	} ret_t;

endpackage

// ===== rtl/glzw_tables.sv =====
// ----------------------------------------------------------------------------
// glzw_tables
// Hash head memory and string entry memory, both with registered synchronous reads.
// ----------------------------------------------------------------------------
module glzw_tables #(
	parameter int HASH_SLOTS = glzw_pkg::HASH_SLOTS_DEF,
	localparam int HASH_AW = $clog2(HASH_SLOTS)
) (
	input  logic                        clk,
	input  logic                        head_re,
	input  logic [HASH_AW-1:0]          head_raddr,
	input  logic                        head_we,
	input  logic [HASH_AW-1:0]          head_waddr,
	input  logic [glzw_pkg::CODE_W-1:0] head_wdata,
	output logic [glzw_pkg::CODE_W-1:0] head_rdata,
	input  glzw_pkg::ent_req_t          ent_req,
	output glzw_pkg::entry_t            ent_rdata
);
	import glzw_pkg::*;

	logic [CODE_W-1:0] head_mem [HASH_SLOTS];
	entry_t            ent_mem  [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		if (head_re) begin
			head_rdata <= head_mem[head_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ent_req.we) begin
			ent_mem[ent_req.waddr] <= ent_req.wdata;
		end
		if (ent_req.re) begin
			ent_rdata <= ent_mem[ent_req.raddr];
		end
	end

endmodule

// ===== rtl/gif_lzw_encoder_unit.sv =====
// Operation: a pixel reads its hash head, then walks the entry chain unless the slot
// holds no live code; a miss packs the pending code and drains its bytes, and a table
// restart also sends the pixel code and a clear code. Output stalls hold any byte push.
// Items are taken one at a time, only while idle; the chain walk goes through the entry
// memory's single read port.
// Reset: asynchronous; afterwards the head memory is swept to zero before the first
// item is taken. The color_bits register resets to 8.
// ----------------------------------------------------------------------------
// gif_lzw_encoder_unit
// Variable-width LZW encoder for GIF raster data with LSB-first byte packing.
// ----------------------------------------------------------------------------
module gif_lzw_encoder_unit #(
	parameter int HASH_SLOTS = glzw_pkg::HASH_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] pixel,
	output logic       byte_valid,
	input  logic       byte_ready,
	output logic [7:0] data_byte,
	output logic       last
);
	import glzw_pkg::*;

	localparam int HASH_AW = $clog2(HASH_SLOTS);

	state_t state_q, state_d;
	ret_t   ret_q;

	logic [3:0]         color_bits_q;
	logic [3:0]         root_q;
	logic               active_q;
	logic [3:0]         width_q;
	logic [12:0]        nfc_q;
	logic [12:0]        pend_q;
	logic [7:0]         pix_q;
	logic [11:0]        idx_q;
	logic [11:0]        headv_q;
	logic [HASH_AW-1:0] hash_q;
	logic [11:0]        code_q;
	logic [19:0]        acc_q;
	logic [4:0]         cnt_q;
	logic [HASH_AW-1:0] init_q;
	logic               bv_q;
	logic [7:0]         byte_q;
	logic               last_q;

	logic               head_re, head_we;
	logic [HASH_AW-1:0] head_raddr, head_waddr;
	logic [11:0]        head_wdata, head_rdata;
	ent_req_t           ent_req;
	entry_t             ent_rdata;

	logic [11:0]        clear_code, end_code;
	logic [12:0]        first_code;
	logic [7:0]         pix_mask, in_pix;
	logic [HASH_AW-1:0] in_hash;
	logic [3:0]         root_new;
	logic               accept, out_free, head_ok, ent_match, link_ok, grow, table_full;
	logic               push, push_last;
	logic [7:0]         push_byte;

	glzw_tables #(.HASH_SLOTS(HASH_SLOTS)) u_tables (
		.clk        (clk),
		.head_re    (head_re),
		.head_raddr (head_raddr),
		.head_we    (head_we),
		.head_waddr (head_waddr),
		.head_wdata (head_wdata),
		.head_rdata (head_rdata),
		.ent_req    (ent_req),
		.ent_rdata  (ent_rdata)
	);

	assign clear_code = 12'd1 << root_q;
	assign end_code   = clear_code | 12'd1;
	assign first_code = {1'b0, clear_code} + 13'd2;
	assign pix_mask   = 8'((9'd1 << root_q) - 9'd1);
	assign in_pix     = pixel & pix_mask;
	assign in_hash    = pend_q[HASH_AW-1:0] ^ HASH_AW'(in_pix);
	assign root_new   = (color_bits_q < 4'd2) ? 4'd2 :
	                    ((color_bits_q > 4'd8) ? 4'd8 : color_bits_q);

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_free   = !bv_q || byte_ready;

	// Heads and links left over from an earlier table generation fall outside
	// the live code range; links must also point to strictly older entries.
	assign head_ok    = ({1'b0, head_rdata} >= first_code) && ({1'b0, head_rdata} < nfc_q);
	assign ent_match  = (ent_rdata.prefix == pend_q[11:0]) && (ent_rdata.suffix == pix_q);
	assign link_ok    = ({1'b0, ent_rdata.chain} >= first_code) && (ent_rdata.chain < idx_q);
	assign grow       = (nfc_q >= (13'd1 << width_q)) && (width_q < 4'(MAX_CODE_W));
	assign table_full = (nfc_q == 13'(TABLE_ENTRIES - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (init_q == HASH_AW'(HASH_SLOTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_START: if (!active_q) state_d = ST_ROOT;
						CMD_PIXEL: if (active_q && pend_q != EMPTY_CODE) state_d = ST_HEAD;
						CMD_END:   if (active_q) state_d = ST_PUT;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_ROOT: if (out_free) state_d = ST_PUT;
			ST_HEAD: state_d = head_ok ? ST_ENT : ST_PUT;
			ST_ENT: begin
				if (ent_match) state_d = ST_IDLE;
				else if (link_ok) state_d = ST_ENT;
				else state_d = ST_PUT;
			end
			ST_PUT: state_d = ST_DRAIN;
			ST_DRAIN: begin
				if (cnt_q < 5'd8) begin
					case (ret_q)
						RET_CLR:  state_d = ST_IDLE;
						RET_ADD:  state_d = table_full ? ST_PUT : ST_IDLE;
						RET_FULL: state_d = ST_PUT;
						RET_END1: state_d = ST_PUT;
						RET_END2: state_d = (cnt_q != 5'd0) ? ST_FLUSH : ST_IDLE;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_FLUSH: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		head_re    = 1'b0;
		head_raddr = in_hash;
		head_we    = 1'b0;
		head_waddr = hash_q;
		head_wdata = nfc_q[11:0];
		ent_req    = '{re: 1'b0, raddr: head_rdata, we: 1'b0, waddr: nfc_q[11:0],
		               wdata: '{prefix: pend_q[11:0], suffix: pix_q, chain: headv_q}};
		push       = 1'b0;
		push_byte  = acc_q[7:0];
		push_last  = 1'b0;
		case (state_q)
			ST_INIT: begin
				head_we    = 1'b1;
				head_waddr = init_q;
				head_wdata = '0;
			end
			ST_IDLE: begin
				head_re = accept && (cmd == CMD_PIXEL) && active_q && (pend_q != EMPTY_CODE);
			end
			ST_ROOT: begin
				push      = out_free;
				push_byte = {4'd0, root_q};
			end
			ST_HEAD: begin
				ent_req.re = head_ok;
			end
			ST_ENT: begin
				ent_req.re    = !ent_match && link_ok;
				ent_req.raddr = ent_rdata.chain;
			end
			ST_DRAIN: begin
				if (cnt_q >= 5'd8) begin
					push      = out_free;
					push_last = (ret_q == RET_END2) && (cnt_q == 5'd8);
				end else if (ret_q == RET_ADD) begin
					head_we    = 1'b1;
					ent_req.we = 1'b1;
				end
			end
			ST_FLUSH: begin
				push      = out_free;
				push_last = 1'b1;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			ret_q        <= RET_CLR;
			color_bits_q <= COLOR_BITS_RESET;
			root_q       <= 4'd2;
			active_q     <= 1'b0;
			width_q      <= '0;
			nfc_q        <= '0;
			pend_q       <= EMPTY_CODE;
			acc_q        <= '0;
			cnt_q        <= '0;
			init_q       <= '0;
			bv_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) color_bits_q <= cfg_wr_data;
			if (push) bv_q <= 1'b1;
			else if (byte_ready) bv_q <= 1'b0;
			case (state_q)
				ST_INIT: init_q <= init_q + 1'b1;
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_START: begin
								if (!active_q) begin
									root_q   <= root_new;
									active_q <= 1'b1;
									acc_q    <= '0;
									cnt_q    <= '0;
									width_q  <= root_new + 4'd1;
								end
							end
							CMD_PIXEL: begin
								if (active_q && pend_q == EMPTY_CODE) pend_q <= {5'd0, in_pix};
							end
							CMD_END: begin
								if (active_q) begin
									if (pend_q != EMPTY_CODE) begin
										code_q <= pend_q[11:0];
										ret_q  <= RET_END1;
									end else begin
										code_q <= end_code;
										ret_q  <= RET_END2;
									end
								end
							end
							default: ret_q <= ret_q;
						endcase
					end
				end
				ST_ROOT: begin
					if (out_free) begin
						code_q <= clear_code;
						ret_q  <= RET_CLR;
					end
				end
				ST_HEAD: begin
					if (!head_ok) begin
						code_q <= pend_q[11:0];
						ret_q  <= RET_ADD;
					end
				end
				ST_ENT: begin
					if (ent_match) begin
						pend_q <= {1'b0, idx_q};
					end else if (!link_ok) begin
						code_q <= pend_q[11:0];
						ret_q  <= RET_ADD;
					end
				end
				ST_PUT: begin
					acc_q <= acc_q | (20'(code_q) << cnt_q[2:0]);
					cnt_q <= cnt_q + 5'(width_q);
				end
				ST_DRAIN: begin
					if (cnt_q >= 5'd8) begin
						if (out_free) begin
							acc_q <= acc_q >> 8;
							cnt_q <= cnt_q - 5'd8;
						end
					end else begin
						case (ret_q)
							RET_CLR: begin
								width_q <= root_q + 4'd1;
								pend_q  <= EMPTY_CODE;
								nfc_q   <= first_code;
							end
							RET_ADD: begin
								if (grow) width_q <= width_q + 4'd1;
								nfc_q  <= nfc_q + 13'd1;
								pend_q <= {5'd0, pix_q};
								if (table_full) begin
									code_q <= {4'd0, pix_q};
									ret_q  <= RET_FULL;
								end
							end
							RET_FULL: begin
								code_q <= clear_code;
								ret_q  <= RET_CLR;
							end
							RET_END1: begin
								code_q <= end_code;
								ret_q  <= RET_END2;
							end
							RET_END2: begin
								if (cnt_q == 5'd0) begin
									active_q <= 1'b0;
									pend_q   <= EMPTY_CODE;
								end
							end
							default: ret_q <= ret_q;
						endcase
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						acc_q    <= '0;
						cnt_q    <= '0;
						active_q <= 1'b0;
						pend_q   <= EMPTY_CODE;
					end
				end
				default: ret_q <= ret_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && cmd == CMD_PIXEL) begin
			pix_q  <= in_pix;
			hash_q <= in_hash;
		end
		if (state_q == ST_HEAD) begin
			headv_q <= head_rdata;
			idx_q   <= head_rdata;
		end
		if (state_q == ST_ENT && !ent_match && link_ok) idx_q <= ent_rdata.chain;
		if (push) begin
			byte_q <= push_byte;
			last_q <= push_last;
		end
	end

	assign byte_valid = bv_q;
	assign data_byte  = byte_q;
	assign last       = last_q;

endmodule

// ===== rtl/glzw_checker.sv =====
// ----------------------------------------------------------------------------
// glzw_checker
// Port-level checks of the GIF LZW encoder, bound to the top level.
// ----------------------------------------------------------------------------
module glzw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       byte_valid,
	input logic       byte_ready,
	input logic [7:0] data_byte,
	input logic       last
);

	// A stalled output transaction keeps its byte and flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(data_byte) && $stable(last))
		else $error("output changed while stalled");

	// Bytes are produced only while an item is being worked on, never while idle.
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(byte_valid) |-> !$past(item_ready))
		else $error("byte appeared while the input side was idle");

	// An offered output transaction always carries defined bits.
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid |-> !$isunknown({data_byte, last}))
		else $error("output byte carries unknown bits");

endmodule

bind gif_lzw_encoder_unit glzw_checker u_glzw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_ready (item_ready),
	.byte_valid (byte_valid),
	.byte_ready (byte_ready),
	.data_byte  (data_byte),
	.last       (last)
);

// ===== verif/tb_gif_lzw_encoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gif_lzw_encoder_unit
// Drives start, pixel, end and unused commands into the GIF LZW encoder, predicts the
// packed byte stream with a behavioral encoder, and checks every output byte.
// ----------------------------------------------------------------------------
module tb_gif_lzw_encoder_unit;
	import glzw_pkg::*;

	localparam int HSLOTS = HASH_SLOTS_DEF;
	localparam int HS_AW  = $clog2(HSLOTS);
	localparam logic [12:0] NO_CODE = 13'h1FFF;
	localparam logic [1:0]  CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} out_byte_t;

	// Behavioral LZW encoder and queue of expected bytes.
	class lzw_scoreboard;
		logic [3:0]  color_bits;
		logic [12:0] heads [HSLOTS];
		logic [11:0] ent_prefix [TABLE_ENTRIES];
		logic [7:0]  ent_suffix [TABLE_ENTRIES];
		logic [12:0] ent_chain [TABLE_ENTRIES];
		int unsigned free_code, code_w, root, bit_cnt;
		logic [12:0] pend;
		logic [31:0] acc;
		bit          active;
		out_byte_t   bytes_due[$];
		int          n_fail;

		function new();
			color_bits = COLOR_BITS_RESET;
			root = 2;
			foreach (heads[i]) heads[i] = NO_CODE;
			free_code = 0;
			code_w = 0;
			pend = NO_CODE;
			acc = 0;
			bit_cnt = 0;
			active = 0;
			n_fail = 0;
		endfunction

		function void push_byte(logic [7:0] b);
			out_byte_t o;
			o.data_byte = b;
			o.last = 1'b0;
			bytes_due.push_back(o);
		endfunction

		function void pack_code(int unsigned code);
			acc |= (code & 32'hFFF) << (bit_cnt & 15);
			bit_cnt += code_w;
			while (bit_cnt >= 8) begin
				push_byte(acc[7:0]);
				acc >>= 8;
				bit_cnt -= 8;
			end
			acc &= 32'hFFFFFF;
		endfunction

		function void restart_table();
			foreach (heads[i]) heads[i] = NO_CODE;
			free_code = (1 << root) + 2;
		endfunction

		function void send_clear();
			pack_code(1 << root);
			code_w = root + 1;
			pend = NO_CODE;
			restart_table();
		endfunction

		function logic [HS_AW-1:0] slot_of(logic [12:0] p, int unsigned e);
			return HS_AW'(((p & (HSLOTS - 1)) ^ e) & (HSLOTS - 1));
		endfunction

		function logic [12:0] lookup(logic [12:0] p, int unsigned e);
			logic [12:0] idx;
			int          guard;
			if (p == NO_CODE) return 13'(e);
			idx = heads[slot_of(p, e)];
			guard = 0;
			while (idx != NO_CODE && guard < TABLE_ENTRIES) begin
				idx = idx & 13'(TABLE_ENTRIES - 1);
				if (ent_prefix[idx[11:0]] == p[11:0] && ent_suffix[idx[11:0]] == 8'(e))
					return idx;
				idx = ent_chain[idx[11:0]];
				guard++;
			end
			return NO_CODE;
		endfunction

		function void insert(logic [12:0] p, int unsigned e);
			logic [HS_AW-1:0] h;
			logic [11:0]      s;
			h = slot_of(p, e);
			s = 12'(free_code);
			ent_prefix[s] = p[11:0];
			ent_suffix[s] = 8'(e);
			ent_chain[s] = heads[h];
			heads[h] = {1'b0, s};
			if (free_code > ((1 << code_w) - 1) && code_w < MAX_CODE_W) code_w++;
			free_code++;
		endfunction

		function void note_item(cmd_t c, logic [7:0] px);
			int unsigned p, n0;
			logic [12:0] idx;
			n0 = bytes_due.size();
			case (c)
				CMD_START: begin
					if (!active) begin
						root = color_bits < 2 ? 2 : (color_bits > 8 ? 8 : color_bits);
						active = 1;
						acc = 0;
						bit_cnt = 0;
						push_byte(8'(root));
						code_w = root + 1;
						pend = NO_CODE;
						restart_table();
						send_clear();
					end
				end
				CMD_PIXEL: begin
					if (active) begin
						p = px & ((1 << root) - 1);
						idx = lookup(pend, p);
						if (idx != NO_CODE) begin
							pend = idx;
						end else begin
							pack_code(32'(pend));
							insert(pend, p);
							pend = 13'(p);
							if (free_code >= TABLE_ENTRIES) begin
								pack_code(32'(pend));
								send_clear();
							end
						end
					end
				end
				CMD_END: begin
					if (active) begin
						if (pend != NO_CODE) pack_code(32'(pend));
						pack_code((1 << root) + 1);
						if (bit_cnt > 0) begin
							push_byte(acc[7:0]);
							acc = 0;
							bit_cnt = 0;
						end
						pend = NO_CODE;
						active = 0;
						if (bytes_due.size() > n0) bytes_due[$].last = 1'b1;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_byte(logic [7:0] b, logic l);
			out_byte_t e;
			if (bytes_due.size() == 0) begin
				$error("unexpected byte: data_byte %0h last %0b", b, l);
				n_fail++;
				return;
			end
			e = bytes_due.pop_front();
			if (b !== e.data_byte) begin
				$error("data_byte: expected %0h, actual %0h", e.data_byte, b);
				n_fail++;
			end
			if (l !== e.last) begin
				$error("last: expected %0b, actual %0b", e.last, l);
				n_fail++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [3:0] cfg_wr_data;
	logic       item_valid;
	logic       item_ready;
	logic [1:0] cmd;
	logic [7:0] pixel;
	logic       byte_valid;
	logic       byte_ready;
	logic [7:0] data_byte;
	logic       last;

	lzw_scoreboard lzw_sb;
	int unsigned   cycle_cnt = 0;
	bit            stalls_on;

	gif_lzw_encoder_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.cmd        (cmd),
		.pixel      (pixel),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.data_byte  (data_byte),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 3000000) begin
			$display("[gif_lzw_encoder_unit] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && byte_valid && byte_ready) lzw_sb.check_byte(data_byte, last);
	end

	// Receiver: random stalls per byte, or always ready when stalls are off.
	initial begin
		int unsigned w;
		byte_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = stalls_on ? $urandom_range(0, 8) : 0;
			@(negedge clk);
			byte_ready = (w == 0);
			if (w != 0) begin
				repeat (w - 1) @(negedge clk);
				@(negedge clk);
				byte_ready = 1'b1;
			end
			@(posedge clk);
			while (!byte_valid) @(posedge clk);
		end
	end

	task automatic send_item(cmd_t c, logic [7:0] px, bit gaps = 1);
		int unsigned w;
		w = (gaps && stalls_on) ? $urandom_range(0, 8) : 0;
		repeat (w) @(negedge clk);
		item_valid = 1'b1;
		cmd = c;
		pixel = px;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		lzw_sb.note_item(c, px);
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic send_raw_cmd3(logic [7:0] px);
		item_valid = 1'b1;
		cmd = CMD_UNUSED;
		pixel = px;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (lzw_sb.bytes_due.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_color_bits(logic [3:0] v);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		lzw_sb.color_bits = v;
	endtask

	// One image of n pixels, mostly drawn from a small alphabet so strings repeat.
	task automatic run_image(int n, int alpha);
		send_item(CMD_START, 8'($urandom_range(0, 255)));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0) send_item(CMD_PIXEL, 8'($urandom_range(0, 255)));
			else send_item(CMD_PIXEL, 8'($urandom_range(0, alpha - 1)));
		end
		send_item(CMD_END, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		cmd_t    c;
		logic [3:0] cb_list [6] = '{4'd1, 4'd8, 4'd2, 4'd15, 4'd0, 4'd5};
		lzw_sb = new();
		stalls_on = 1;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 4'd0;
		item_valid = 1'b0;
		cmd = CMD_START;
		pixel = 8'd0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: stray commands outside an image, then extremes at reset width.
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_END, 8'h00);
		send_raw_cmd3(8'hAA);
		send_item(CMD_START, 8'h00);
		send_item(CMD_START, 8'h00);
		send_item(CMD_PIXEL, 8'h00);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_PIXEL, 8'h55);
		send_item(CMD_PIXEL, 8'hAA);
		send_raw_cmd3(8'h55);
		send_item(CMD_END, 8'hFF);
		// Empty image.
		send_item(CMD_START, 8'h00);
		send_item(CMD_END, 8'h00);
		wait_drained();

		// Register change during an image takes effect at the next start.
		write_color_bits(4'd1);
		send_item(CMD_START, 8'h00);
		wait_drained();
		write_color_bits(4'd8);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_PIXEL, 8'h07);
		send_item(CMD_PIXEL, 8'h03);
		send_item(CMD_END, 8'h00);
		wait_drained();

		// Random images over several register settings.
		foreach (cb_list[k]) begin
			write_color_bits(cb_list[k]);
			stalls_on = (k != 2);
			for (int m = 0; m < 2; m++) begin
				run_image($urandom_range(10, 40), $urandom_range(1, 6));
				if ($urandom_range(0, 3) == 0) begin
					c = cmd_t'($urandom_range(0, 2));
					if (c != CMD_START) send_item(c, 8'($urandom_range(0, 255)));
				end
			end
			wait_drained();
		end
		stalls_on = 1;

		while (lzw_sb.bytes_due.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (lzw_sb.n_fail == 0) begin
			$display("[gif_lzw_encoder_unit] OK");
		end else begin
			$display("[gif_lzw_encoder_unit] ERROR");
		end
		$finish;
	end

endmodule

// ===== gif_lzw_encoder_unit.f =====
rtl/glzw_pkg.sv
rtl/glzw_tables.sv
rtl/gif_lzw_encoder_unit.sv
rtl/glzw_checker.sv
verif/tb_gif_lzw_encoder_unit.sv
